[hw/rtl/bclru_pkg.sv]
// Shared types, constants and the set hash of the block cache tag directory.
`default_nettype none

package bclru_pkg;

   localparam int SET_W   = 6;
   localparam int SETS    = 2 ** SET_W;
   localparam int FILE_W  = 6;
   localparam int BLOCK_W = 32;
   localparam int STAMP_W = 64;
   localparam int OWAY_W  = 2;
   localparam int DEF_WAYS = 4;

   localparam logic [63:0] HASH_MUL_FILE  = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] HASH_MUL_BLOCK = 64'hC2B2AE3D27D4EB4F;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_FILL   = 1'b1;

   typedef struct packed {
      logic [FILE_W-1:0]  file_tag;
      logic [BLOCK_W-1:0] block_tag;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load_req;
      logic scan_start;
      logic scan_step;
      logic commit;
      logic use_scan;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_lookup;
      logic hit;
      logic have_invalid;
      logic scan_last;
   } dp_status_type;

   // Only the low SET_W bits of each 64-bit product reach the set index,
   // so the multiplies are done at that width.
   function automatic logic [SET_W-1:0] set_hash(input logic [FILE_W-1:0] file,
                                                 input logic [BLOCK_W-1:0] block);
      logic [SET_W-1:0] prod_f;
      logic [SET_W-1:0] prod_b;
      prod_f = SET_W'(file) * HASH_MUL_FILE[SET_W-1:0];
      prod_b = block[SET_W-1:0] * HASH_MUL_BLOCK[SET_W-1:0];
      return prod_f ^ prod_b;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/bclru_if.sv]
// Request and response channel interfaces of the block cache tag directory.
`default_nettype none

interface bclru_req_if import bclru_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               command;
   logic [FILE_W-1:0]  file_index;
   logic [BLOCK_W-1:0] block_number;
   logic [OWAY_W-1:0]  fill_way;

   modport source(output valid, command, file_index, block_number, fill_way,
                  input ready);
   modport sink(input valid, command, file_index, block_number, fill_way,
                output ready);
endinterface

interface bclru_rsp_if import bclru_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              hit;
   logic [SET_W-1:0]  set_index;
   logic [OWAY_W-1:0] way;

   modport source(output valid, hit, set_index, way, input ready);
   modport sink(input valid, hit, set_index, way, output ready);
endinterface

`default_nettype wire

[hw/rtl/bclru_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bclru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bclru_ctrl.sv]
// Controller state machine: request handshake, sequencing and response valid.
`default_nettype none

module bclru_ctrl import bclru_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // A miss with every way valid needs the stamp scan first.
            if (status.is_lookup && !status.hit && !status.have_invalid) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.use_scan = 1'b1;
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bclru_dp.sv]
// Datapath: set hash, tag memory, valid bits, tag compare, stamp scan and use clock.
`default_nettype none

module bclru_dp import bclru_pkg::*; #(
   parameter int WAYS = DEF_WAYS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_command,
   input  wire logic [FILE_W-1:0]  req_file_index,
   input  wire logic [BLOCK_W-1:0] req_block_number,
   input  wire logic [OWAY_W-1:0]  req_fill_way,
   input  wire ctrl_cmd_type       cmd,
   output dp_status_type           status,
   output logic                    rsp_hit,
   output logic [SET_W-1:0]        rsp_set_index,
   output logic [OWAY_W-1:0]       rsp_way
);

   localparam int WAY_W = $clog2(WAYS);
   localparam int ROW_W = WAYS * ENTRY_W;

   // Latched request.
   logic               command_ff, command_in;
   logic [FILE_W-1:0]  file_ff, file_in;
   logic [BLOCK_W-1:0] block_ff, block_in;
   logic [OWAY_W-1:0]  fill_way_ff, fill_way_in;
   logic [SET_W-1:0]   set_ff, set_in;

   logic [SETS-1:0][WAYS-1:0] valid_ff;
   logic [STAMP_W-1:0]        clock_ff, clock_in;

   logic [WAY_W-1:0]   idx_ff, idx_in;
   logic [WAY_W-1:0]   min_way_ff, min_way_in;
   logic [STAMP_W-1:0] min_stamp_ff, min_stamp_in;

   logic               rsp_hit_ff, rsp_hit_in;
   logic [SET_W-1:0]   rsp_set_ff, rsp_set_in;
   logic [OWAY_W-1:0]  rsp_way_ff, rsp_way_in;

   logic [ROW_W-1:0]           ram_rd_data;
   entry_type [WAYS-1:0]       rd_row;
   entry_type [WAYS-1:0]       wr_row;
   logic [WAYS-1:0]            set_valid;
   logic                       hit;
   logic [WAY_W-1:0]           hit_way;
   logic                       have_invalid;
   logic [WAY_W-1:0]           inv_way;
   logic                       in_range;
   logic                       do_write;
   logic [WAY_W-1:0]           wr_way;
   logic [WAY_W-1:0]           fill_idx;
   logic [WAY_W-1:0]           miss_way;
   logic [STAMP_W-1:0]         next_clock;

   bclru_ram #(
      .WIDTH(ROW_W),
      .DEPTH(SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (set_ff),
      .wr_data (wr_row),
      .rd_en   (cmd.load_req),
      .rd_addr (set_in),
      .rd_data (ram_rd_data)
   );

   assign rd_row     = ram_rd_data;
   assign set_valid  = valid_ff[set_ff];
   assign in_range   = (32'(fill_way_ff) < 32'(WAYS));
   assign fill_idx   = WAY_W'(fill_way_ff);
   assign next_clock = clock_ff + STAMP_W'(1);

   // Request capture; the set index also addresses the read in the accept cycle.
   always_comb begin
      command_in  = command_ff;
      file_in     = file_ff;
      block_in    = block_ff;
      fill_way_in = fill_way_ff;
      set_in      = set_hash(req_file_index, req_block_number);
      if (cmd.load_req) begin
         command_in  = req_command;
         file_in     = req_file_index;
         block_in    = req_block_number;
         fill_way_in = req_fill_way;
      end
   end

   // The lowest matching way wins; the highest invalid way is the free victim.
   always_comb begin
      hit          = 1'b0;
      hit_way      = '0;
      have_invalid = 1'b0;
      inv_way      = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (set_valid[w] && rd_row[w].file_tag == file_ff &&
             rd_row[w].block_tag == block_ff) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         if (!set_valid[w]) begin
            have_invalid = 1'b1;
            inv_way      = WAY_W'(w);
         end
      end
   end

   assign status.is_lookup    = (command_ff == CMD_LOOKUP);
   assign status.hit          = hit;
   assign status.have_invalid = have_invalid;
   assign status.scan_last    = (idx_ff == WAY_W'(WAYS - 1));

   // Oldest-stamp search, one way per cycle; a strict compare keeps the lower way on ties.
   always_comb begin
      idx_in       = idx_ff;
      min_way_in   = min_way_ff;
      min_stamp_in = min_stamp_ff;
      if (cmd.scan_start) begin
         idx_in       = WAY_W'(1);
         min_way_in   = '0;
         min_stamp_in = rd_row[0].stamp;
      end else if (cmd.scan_step) begin
         idx_in = idx_ff + WAY_W'(1);
         if (rd_row[idx_ff].stamp < min_stamp_ff) begin
            min_way_in   = idx_ff;
            min_stamp_in = rd_row[idx_ff].stamp;
         end
      end
   end

   // Read-modify-write of the set row on a hit or an in-range fill.
   always_comb begin
      do_write = cmd.commit &&
                 ((command_ff == CMD_FILL && in_range) || (command_ff == CMD_LOOKUP && hit));
      wr_way   = (command_ff == CMD_FILL) ? fill_idx : hit_way;
      wr_row   = rd_row;
      wr_row[wr_way].stamp = next_clock;
      if (command_ff == CMD_FILL) begin
         wr_row[wr_way].file_tag  = file_ff;
         wr_row[wr_way].block_tag = block_ff;
      end
      clock_in = do_write ? next_clock : clock_ff;

      miss_way   = cmd.use_scan ? min_way_ff : inv_way;
      rsp_hit_in = rsp_hit_ff;
      rsp_set_in = rsp_set_ff;
      rsp_way_in = rsp_way_ff;
      if (cmd.commit) begin
         rsp_set_in = set_ff;
         if (command_ff == CMD_FILL) begin
            rsp_hit_in = 1'b0;
            rsp_way_in = fill_way_ff;
         end else if (hit && !cmd.use_scan) begin
            rsp_hit_in = 1'b1;
            rsp_way_in = OWAY_W'(hit_way);
         end else begin
            rsp_hit_in = 1'b0;
            rsp_way_in = OWAY_W'(miss_way);
         end
      end
   end

   always_ff @(posedge clock) begin
      command_ff   <= command_in;
      file_ff      <= file_in;
      block_ff     <= block_in;
      fill_way_ff  <= fill_way_in;
      if (cmd.load_req) begin
         set_ff <= set_in;
      end
      idx_ff       <= idx_in;
      min_way_ff   <= min_way_in;
      min_stamp_ff <= min_stamp_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_set_ff   <= rsp_set_in;
      rsp_way_ff   <= rsp_way_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         clock_ff <= '0;
      end else begin
         clock_ff <= clock_in;
         if (do_write && command_ff == CMD_FILL) begin
            valid_ff[set_ff][wr_way] <= 1'b1;
         end
      end
   end

   assign rsp_hit       = rsp_hit_ff;
   assign rsp_set_index = rsp_set_ff;
   assign rsp_way       = rsp_way_ff;

endmodule

`default_nettype wire

[hw/rtl/block_cache_tag_lru_top.sv]
// Top level of the block cache tag directory with LRU replacement by timestamp.
//
// The req_if channel carries one word per request: command (lookup or fill),
// file_index, block_number and fill_way. The rsp_if channel returns exactly
// one word per request: hit, set_index and way (hit way, victim way on a miss,
// or the filled way). Both use valid/ready; a word moves when both are high.
//
// A request is taken only while the block is idle. It reads its set row from
// the tag RAM in the accept cycle; the lookup state compares the tags and
// loads the response word into the output register. A lookup miss with every
// way valid first searches the stamps one way per cycle, and the finish state
// loads the word. No new request is taken until the word is loaded; the single
// read port and read-modify-write of the set row keep requests apart.
//
// The output register parts the two sides: the next request is accepted while
// a response waits, and that request then holds at its final step until the
// receiver takes the pending word. Reset clears all valid bits and the use
// clock at once; tag RAM contents are not reset and count only for valid ways.
`default_nettype none

module block_cache_tag_lru_top import bclru_pkg::*; #(
   parameter int WAYS = DEF_WAYS
) (
   input wire logic     clock,
   input wire logic     reset,
   bclru_req_if.sink    req_if,
   bclru_rsp_if.source  rsp_if
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   bclru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bclru_dp #(
      .WAYS(WAYS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_if.command),
      .req_file_index   (req_if.file_index),
      .req_block_number (req_if.block_number),
      .req_fill_way     (req_if.fill_way),
      .cmd              (cmd),
      .status           (status),
      .rsp_hit          (rsp_if.hit),
      .rsp_set_index    (rsp_if.set_index),
      .rsp_way          (rsp_if.way)
   );

endmodule

`default_nettype wire

[sim/tb_block_cache_tag_lru_top.sv]
// Self-checking testbench for the block cache tag directory with LRU replacement.
`timescale 1ns / 1ps

module tb_block_cache_tag_lru_top;
   import bclru_pkg::*;

   localparam int NWAYS        = DEF_WAYS;
   localparam int RANDOM_WORDS = 650;
   localparam int HOT_SETS     = 6;
   localparam int KEYS_PER_SET = 6;

   typedef struct packed {
      logic               command;
      logic [FILE_W-1:0]  file_index;
      logic [BLOCK_W-1:0] block_number;
      logic [OWAY_W-1:0]  fill_way;
   } cache_req_t;

   typedef struct packed {
      logic              hit;
      logic [SET_W-1:0]  set_index;
      logic [OWAY_W-1:0] way;
   } cache_rsp_t;

   logic clock;
   logic reset;

   bclru_req_if req_bus();
   bclru_rsp_if rsp_bus();

   block_cache_tag_lru_top #(.WAYS(NWAYS)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // Shadow copy of the tag directory.
   bit                 line_valid [SETS][NWAYS];
   logic [FILE_W-1:0]  line_file  [SETS][NWAYS];
   logic [BLOCK_W-1:0] line_block [SETS][NWAYS];
   logic [STAMP_W-1:0] line_stamp [SETS][NWAYS];
   logic [STAMP_W-1:0] use_tick;

   cache_req_t pending_reqs[$];
   cache_rsp_t expected_rsps[$];
   cache_req_t next_req;
   int total_reqs;
   int words_in;
   int fail_count;
   int send_gap;
   int hold_left;
   int stall_len;
   bit long_hold_done;
   bit calm;
   int calm_left;

   function automatic logic [SET_W-1:0] hashed_set(input logic [FILE_W-1:0] file,
                                                   input logic [BLOCK_W-1:0] block);
      logic [63:0] mix;
      mix = (64'(file) * HASH_MUL_FILE) ^ (64'(block) * HASH_MUL_BLOCK);
      return mix[SET_W-1:0];
   endfunction

   // The set is (file*21 xor block*15) mod 64, and 47 is the inverse of 15 mod 64,
   // so the low block bits can be solved for any wanted set.
   function automatic logic [BLOCK_W-1:0] block_in_set(input logic [SET_W-1:0] set_i,
                                                       input logic [FILE_W-1:0] file,
                                                       input logic [BLOCK_W-1:0] upper);
      logic [5:0] low;
      low = (set_i ^ (file * 6'd21)) * 6'd47;
      return {upper[BLOCK_W-1:6], low};
   endfunction

   function automatic cache_rsp_t tag_dir_access(input cache_req_t rq);
      cache_rsp_t res;
      logic [SET_W-1:0] set_i;
      int match_way;
      int empty_way;
      int oldest_way;
      set_i = hashed_set(rq.file_index, rq.block_number);
      res.hit = 1'b0;
      res.set_index = set_i;
      res.way = rq.fill_way;
      if (rq.command == CMD_FILL) begin
         if (rq.fill_way < NWAYS) begin
            use_tick = use_tick + 1;
            line_valid[set_i][rq.fill_way] = 1'b1;
            line_file[set_i][rq.fill_way]  = rq.file_index;
            line_block[set_i][rq.fill_way] = rq.block_number;
            line_stamp[set_i][rq.fill_way] = use_tick;
         end
      end else begin
         match_way = -1;
         empty_way = -1;
         oldest_way = -1;
         for (int w = 0; w < NWAYS; w++) begin
            if (!line_valid[set_i][w]) begin
               empty_way = w;
            end else begin
               if (match_way < 0 && line_file[set_i][w] == rq.file_index &&
                   line_block[set_i][w] == rq.block_number)
                  match_way = w;
               if (oldest_way < 0 || line_stamp[set_i][w] < line_stamp[set_i][oldest_way])
                  oldest_way = w;
            end
         end
         if (match_way >= 0) begin
            res.hit = 1'b1;
            res.way = OWAY_W'(match_way);
            use_tick = use_tick + 1;
            line_stamp[set_i][match_way] = use_tick;
         end else if (empty_way >= 0) begin
            res.way = OWAY_W'(empty_way);
         end else begin
            res.way = OWAY_W'(oldest_way);
         end
      end
      return res;
   endfunction

   // Mostly short gaps, a few long ones, none at all while calm.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic queue_req(input logic cmd, input logic [FILE_W-1:0] file,
                            input logic [BLOCK_W-1:0] block, input logic [OWAY_W-1:0] way);
      cache_req_t rq;
      rq.command = cmd;
      rq.file_index = file;
      rq.block_number = block;
      rq.fill_way = way;
      pending_reqs.push_back(rq);
   endtask

   task automatic report_mismatch(input string what, input cache_rsp_t got,
                                  input cache_rsp_t exp_rsp);
      if (fail_count < 100)
         $display("%0t: %s: got hit=%0b set=%0d way=%0d, expected hit=%0b set=%0d way=%0d",
                  $realtime, what, got.hit, got.set_index, got.way,
                  exp_rsp.hit, exp_rsp.set_index, exp_rsp.way);
      fail_count++;
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (reset || calm_left == 0) begin
         calm <= ($urandom_range(0, 2) == 0);
         calm_left <= $urandom_range(50, 200);
      end else begin
         calm_left <= calm_left - 1;
      end
   end

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap > 0 || pending_reqs.size() == 0) begin
            req_bus.valid <= 1'b0;
            if (send_gap > 0)
               send_gap <= send_gap - 1;
         end else begin
            next_req = pending_reqs.pop_front();
            req_bus.valid        <= 1'b1;
            req_bus.command      <= next_req.command;
            req_bus.file_index   <= next_req.file_index;
            req_bus.block_number <= next_req.block_number;
            req_bus.fill_way     <= next_req.fill_way;
            // Keep offering words while the receiver is held off.
            send_gap <= (hold_left > 0) ? 0 : gap_len();
         end
      end
   end

   // Response receiver; one long hold-off lets the block back up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 0;
         long_hold_done <= 1'b0;
      end else if (!long_hold_done && words_in >= 200) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 80;
         long_hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         stall_len = gap_len();
         if (stall_len > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left <= stall_len - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Monitor: predicts on each accepted request, checks each accepted response.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            expected_rsps.push_back(tag_dir_access({req_bus.command, req_bus.file_index,
                                                    req_bus.block_number,
                                                    req_bus.fill_way}));
            words_in++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response",
                               {rsp_bus.hit, rsp_bus.set_index, rsp_bus.way}, '0);
            end else begin
               if (rsp_bus.hit !== expected_rsps[0].hit ||
                   rsp_bus.set_index !== expected_rsps[0].set_index ||
                   rsp_bus.way !== expected_rsps[0].way)
                  report_mismatch("response mismatch",
                                  {rsp_bus.hit, rsp_bus.set_index, rsp_bus.way},
                                  expected_rsps[0]);
               void'(expected_rsps.pop_front());
            end
         end
      end
   end

   initial begin
      logic [FILE_W-1:0]  dk_file  [5];
      logic [BLOCK_W-1:0] dk_block [5];
      logic [SET_W-1:0]   hot_set  [HOT_SETS];
      logic [FILE_W-1:0]  pool_file  [HOT_SETS][KEYS_PER_SET];
      logic [BLOCK_W-1:0] pool_block [HOT_SETS][KEYS_PER_SET];
      int s;
      int k;
      int r;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_LOOKUP;
      req_bus.file_index = '0;
      req_bus.block_number = '0;
      req_bus.fill_way = '0;
      rsp_bus.ready = 1'b0;
      words_in = 0;
      fail_count = 0;
      use_tick = '0;
      foreach (line_valid[i, j])
         line_valid[i][j] = 1'b0;

      // Directed: field extremes, filling a set way by way, LRU victim,
      // overwrite of a valid way and a duplicate tag in two ways.
      queue_req(CMD_LOOKUP, 6'd0, 32'd0, 2'd0);
      queue_req(CMD_LOOKUP, 6'd63, 32'hFFFF_FFFF, 2'd3);
      queue_req(CMD_FILL, 6'd63, 32'hFFFF_FFFF, 2'd3);
      queue_req(CMD_LOOKUP, 6'd63, 32'hFFFF_FFFF, 2'd0);
      queue_req(CMD_FILL, 6'd0, 32'd0, 2'd0);
      queue_req(CMD_LOOKUP, 6'd0, 32'd0, 2'd3);
      for (int i = 0; i < 5; i++) begin
         dk_file[i] = FILE_W'(i + 1);
         dk_block[i] = block_in_set(6'd5, dk_file[i], $urandom);
      end
      queue_req(CMD_FILL, dk_file[0], dk_block[0], 2'd0);
      queue_req(CMD_LOOKUP, dk_file[1], dk_block[1], 2'd0);
      queue_req(CMD_FILL, dk_file[1], dk_block[1], 2'd1);
      queue_req(CMD_FILL, dk_file[2], dk_block[2], 2'd2);
      queue_req(CMD_LOOKUP, dk_file[3], dk_block[3], 2'd0);
      queue_req(CMD_FILL, dk_file[3], dk_block[3], 2'd3);
      queue_req(CMD_LOOKUP, dk_file[4], dk_block[4], 2'd0);
      queue_req(CMD_LOOKUP, dk_file[0], dk_block[0], 2'd0);
      queue_req(CMD_LOOKUP, dk_file[4], dk_block[4], 2'd0);
      queue_req(CMD_FILL, dk_file[4], dk_block[4], 2'd1);
      queue_req(CMD_FILL, dk_file[4], dk_block[4], 2'd2);
      queue_req(CMD_LOOKUP, dk_file[4], dk_block[4], 2'd0);
      queue_req(CMD_LOOKUP, dk_file[1], dk_block[1], 2'd0);
      queue_req(CMD_LOOKUP, dk_file[3], dk_block[3], 2'd0);

      // Random part: most traffic hits a few crowded sets, so hits, misses
      // and LRU victims of full sets all come up often.
      for (int i = 0; i < HOT_SETS; i++) begin
         hot_set[i] = SET_W'($urandom_range(0, SETS - 1));
         for (int j = 0; j < KEYS_PER_SET; j++) begin
            pool_file[i][j] = FILE_W'($urandom_range(0, 63));
            pool_block[i][j] = block_in_set(hot_set[i], pool_file[i][j], $urandom);
         end
      end
      total_reqs = pending_reqs.size() + RANDOM_WORDS;
      while (pending_reqs.size() < total_reqs) begin
         r = $urandom_range(0, 99);
         s = $urandom_range(0, HOT_SETS - 1);
         k = $urandom_range(0, KEYS_PER_SET - 1);
         if (r < 75) begin
            queue_req(CMD_LOOKUP, pool_file[s][k], pool_block[s][k],
                      OWAY_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 9) < 6)
               queue_req(CMD_FILL, pool_file[s][k], pool_block[s][k],
                         OWAY_W'($urandom_range(0, 3)));
         end else if (r < 85) begin
            queue_req(CMD_FILL, pool_file[s][k], pool_block[s][k],
                      OWAY_W'($urandom_range(0, 3)));
         end else begin
            queue_req(1'($urandom_range(0, 1)), FILE_W'($urandom_range(0, 63)), $urandom,
                      OWAY_W'($urandom_range(0, 3)));
         end
      end
      total_reqs = pending_reqs.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (words_in < total_reqs || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (4 * (NWAYS + 2)) @(posedge clock);

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
